FILE: src/rth_pkg.sv
`default_nettype none

package rth_pkg;

    localparam int PIX_W         = 8;
    localparam int HUE_FRAC_BITS = 6;
    localparam int HUE_W         = 15;
    localparam int SAT_W         = 17;
    localparam int LIT_W         = 9;
    localparam int SAT_FRAC      = 16;

    localparam logic [SAT_W-1:0] SAT_ONE = SAT_W'(1 << SAT_FRAC);

    // 60 * channel difference needs six more bits than a channel
    localparam int DIFF60_W  = PIX_W + 6;
    localparam int HUE_NUM_W = DIFF60_W + HUE_FRAC_BITS;

    // restoring division, one quotient bit per step
    localparam int DIV_STEPS       = 18;
    localparam int STEPS_PER_STAGE = 3;
    localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;
    localparam int DIV_WORD_W      = DIV_STEPS + PIX_W;

    // front stage, divider stages, output stage
    localparam int PIPE_STAGES = DIV_STAGES + 2;

    // room for 360 degrees scaled by the fraction bits, and for a whole quotient
    localparam int HUE_CALC_W = (10 + HUE_FRAC_BITS > DIV_STEPS) ?
                                (10 + HUE_FRAC_BITS) : DIV_STEPS;

    typedef enum logic [1:0] {
        HB_RED,
        HB_GREEN,
        HB_BLUE,
        HB_WRAP
    } t_hue_base;

    typedef struct packed {
        logic [PIX_W-1:0]     rem;
        logic [DIV_STEPS-1:0] bits;
        logic [PIX_W-1:0]     divisor;
    } t_lane;

    typedef struct packed {
        logic            grey;
        logic            sub;
        t_hue_base       base;
        logic [LIT_W-1:0] sum;
    } t_side;

    typedef struct packed {
        t_lane hue;
        t_lane sat;
        t_side side;
    } t_stage;

    // one step: shift in the next dividend bit, subtract when it fits
    function automatic t_lane div_step(input t_lane lane);
        t_lane          res;
        logic [PIX_W:0] part;
        part = {lane.rem, lane.bits[DIV_STEPS-1]};
        res  = lane;
        if (part >= {1'b0, lane.divisor}) begin
            res.rem  = PIX_W'(part - {1'b0, lane.divisor});
            res.bits = {lane.bits[DIV_STEPS-2:0], 1'b1};
        end else begin
            res.rem  = part[PIX_W-1:0];
            res.bits = {lane.bits[DIV_STEPS-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: src/rth_if.sv
`default_nettype none

interface rth_pix_if import rth_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface rth_hsl_if import rth_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [LIT_W-1:0] lightness_sum;

    modport source (output valid, output hue, output saturation, output lightness_sum,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness_sum,
                    output ready);
endinterface

`default_nettype wire

FILE: src/rth_front.sv
`default_nettype none

module rth_front import rth_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    output t_stage           o_stage
);

    t_stage                r_stage;
    t_stage                n_stage;

    logic                  w_red_max;
    logic                  w_green_max;
    logic [PIX_W-1:0]      w_max;
    logic [PIX_W-1:0]      w_min;
    logic [PIX_W-1:0]      w_delta;
    logic [PIX_W-1:0]      w_diff;
    logic [LIT_W-1:0]      w_sum;
    logic [PIX_W-1:0]      w_denom;
    logic [DIFF60_W-1:0]   w_diff60;
    logic [HUE_NUM_W-1:0]  w_num;
    logic [DIV_WORD_W-1:0] w_hue_word;
    logic [DIV_WORD_W-1:0] w_sat_word;

    always_comb begin
        w_red_max   = (i_red >= i_green) && (i_red >= i_blue);
        w_green_max = !w_red_max && (i_green >= i_blue);

        w_max = w_red_max ? i_red : (w_green_max ? i_green : i_blue);
        if ((i_red <= i_green) && (i_red <= i_blue)) begin
            w_min = i_red;
        end else if (i_green <= i_blue) begin
            w_min = i_green;
        end else begin
            w_min = i_blue;
        end
        w_delta = w_max - w_min;
        w_sum   = LIT_W'(w_max) + LIT_W'(w_min);
        w_denom = (w_sum <= LIT_W'(255)) ? w_sum[PIX_W-1:0]
                                         : PIX_W'(LIT_W'(510) - w_sum);

        n_stage.side.grey = (w_delta == '0);
        n_stage.side.sum  = w_sum;

        // hue = base + 60*diff/delta, or base minus that when the sector runs backwards
        if (w_red_max) begin
            if (i_green >= i_blue) begin
                w_diff            = i_green - i_blue;
                n_stage.side.sub  = 1'b0;
                n_stage.side.base = HB_RED;
            end else begin
                w_diff            = i_blue - i_green;
                n_stage.side.sub  = 1'b1;
                n_stage.side.base = HB_WRAP;
            end
        end else if (w_green_max) begin
            n_stage.side.base = HB_GREEN;
            n_stage.side.sub  = (i_blue < i_red);
            w_diff            = (i_blue >= i_red) ? (i_blue - i_red) : (i_red - i_blue);
        end else begin
            n_stage.side.base = HB_BLUE;
            n_stage.side.sub  = (i_red < i_green);
            w_diff            = (i_red >= i_green) ? (i_red - i_green) : (i_green - i_red);
        end

        w_diff60 = (DIFF60_W'(w_diff) << 6) - (DIFF60_W'(w_diff) << 2);
        w_num    = HUE_NUM_W'(w_diff60) << HUE_FRAC_BITS;

        w_hue_word = DIV_WORD_W'(w_num);
        w_sat_word = DIV_WORD_W'(w_delta) << SAT_FRAC;

        // top bits start as partial remainder, already below the divisor
        n_stage.hue.rem     = w_hue_word[DIV_WORD_W-1 -: PIX_W];
        n_stage.hue.bits    = w_hue_word[DIV_STEPS-1:0];
        n_stage.hue.divisor = w_delta;
        n_stage.sat.rem     = w_sat_word[DIV_WORD_W-1 -: PIX_W];
        n_stage.sat.bits    = w_sat_word[DIV_STEPS-1:0];
        n_stage.sat.divisor = w_denom;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

FILE: src/rth_div_stage.sv
`default_nettype none

module rth_div_stage import rth_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_stage i_stage,
    output t_stage o_stage
);

    t_stage r_stage;
    t_stage n_stage;

    always_comb begin
        n_stage = i_stage;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            n_stage.hue = div_step(n_stage.hue);
            n_stage.sat = div_step(n_stage.sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

FILE: src/rth_back.sv
`default_nettype none

module rth_back import rth_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_stage           i_stage,
    output logic [HUE_W-1:0] o_hue,
    output logic [SAT_W-1:0] o_sat,
    output logic [LIT_W-1:0] o_light
);

    localparam logic [8:0] DEG_GREEN = 9'd120;
    localparam logic [8:0] DEG_BLUE  = 9'd240;
    localparam logic [8:0] DEG_WRAP  = 9'd360;

    logic [HUE_W-1:0]      r_hue;
    logic [SAT_W-1:0]      r_sat;
    logic [LIT_W-1:0]      r_light;
    logic [HUE_W-1:0]      n_hue;
    logic [SAT_W-1:0]      n_sat;

    logic [8:0]            w_deg;
    logic [HUE_CALC_W-1:0] w_base;
    logic [HUE_CALC_W-1:0] w_quot;
    logic [HUE_CALC_W-1:0] w_calc;
    logic                  w_inexact;

    always_comb begin
        case (i_stage.side.base)
            HB_RED:   w_deg = '0;
            HB_GREEN: w_deg = DEG_GREEN;
            HB_BLUE:  w_deg = DEG_BLUE;
            HB_WRAP:  w_deg = DEG_WRAP;
            default:  w_deg = '0;
        endcase
        w_base    = HUE_CALC_W'(w_deg) << HUE_FRAC_BITS;
        w_quot    = HUE_CALC_W'(i_stage.hue.bits);
        w_inexact = (i_stage.hue.rem != '0);

        // floor of a backwards sector is base minus the rounded-up quotient
        if (i_stage.side.sub) begin
            w_calc = w_base - w_quot - HUE_CALC_W'(w_inexact);
        end else begin
            w_calc = w_base + w_quot;
        end

        n_hue = i_stage.side.grey ? '0 : w_calc[HUE_W-1:0];
        n_sat = i_stage.side.grey ? '0 : i_stage.sat.bits[SAT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hue   <= n_hue;
            r_sat   <= n_sat;
            r_light <= i_stage.side.sum;
        end
    end

    assign o_hue   = r_hue;
    assign o_sat   = r_sat;
    assign o_light = r_light;

endmodule

`default_nettype wire

FILE: src/rgb_to_hsl_core.sv
`default_nettype none

// RGB to HSL converter for 8-bit pixel streams. One pixel is taken per clock and each gives
// exactly one result: a front stage finds max, min, sector and both dividends, six stages run
// the hue and saturation divisions side by side as restoring division at three quotient bits
// per stage, and an output stage applies the sector base. Throughput is one pixel per cycle
// for as long as the sink takes results; when the sink stalls, full stages hold and empty
// stages still fill, so the input is refused in the same cycle only once every stage holds a
// pixel. Hue is degrees with HUE_FRAC_BITS fraction bits, saturation is Q1.16 and lightness
// is given as max + min.
module rgb_to_hsl_core import rth_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rth_pix_if.sink   i_pix,
    rth_hsl_if.source o_hsl
);

    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] n_vld;
    logic [PIPE_STAGES:0]   w_rdy;
    t_stage                 w_stage [DIV_STAGES+1];

    // a stage takes new data when it is empty or its contents move on
    always_comb begin
        w_rdy[PIPE_STAGES] = o_hsl.ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        for (int k = 0; k < PIPE_STAGES; k++) begin
            if (w_rdy[k]) begin
                n_vld[k] = (k == 0) ? i_pix.valid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    rth_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_rdy[0]),
        .i_red   (i_pix.red_in),
        .i_green (i_pix.green_in),
        .i_blue  (i_pix.blue_in),
        .o_stage (w_stage[0])
    );

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        rth_div_stage u_div (
            .i_clk   (i_clk),
            .i_en    (w_rdy[j+1]),
            .i_stage (w_stage[j]),
            .o_stage (w_stage[j+1])
        );
    end

    rth_back u_back (
        .i_clk   (i_clk),
        .i_en    (w_rdy[PIPE_STAGES-1]),
        .i_stage (w_stage[DIV_STAGES]),
        .o_hue   (o_hsl.hue),
        .o_sat   (o_hsl.saturation),
        .o_light (o_hsl.lightness_sum)
    );

    assign i_pix.ready = w_rdy[0];
    assign o_hsl.valid = r_vld[PIPE_STAGES-1];

endmodule

`default_nettype wire

FILE: src/rth_checker.sv
`default_nettype none

module rth_checker import rth_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [HUE_W-1:0] i_hue,
    input logic [SAT_W-1:0] i_sat,
    input logic [LIT_W-1:0] i_light
);

    // stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_hue) && $stable(i_sat) && $stable(i_light))
        else $error("result changed while stalled");

    // no result straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_sat <= SAT_ONE)
        else $error("saturation above one");

    // zero saturation only for grey, and grey has zero hue
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_sat == '0) |-> (i_hue == '0))
        else $error("grey pixel with nonzero hue");

endmodule

bind rgb_to_hsl_core rth_checker u_rth_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_hsl.valid),
    .i_out_ready (o_hsl.ready),
    .i_hue       (o_hsl.hue),
    .i_sat       (o_hsl.saturation),
    .i_light     (o_hsl.lightness_sum)
);

`default_nettype wire
